// ===== rtl/w2s_pkg.sv =====
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared widths, constants and fixed-point helpers for the point projector.
// ----------------------------------------------------------------------------
`default_nettype none

package w2s_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned COEF_N   = 32;
    localparam int unsigned ADDR_W   = $clog2(COEF_N);
    localparam int unsigned DIM_W    = 14;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned DVD_W    = DATA_W + FRAC_W;
    localparam int unsigned DCNT_W   = $clog2(DVD_W);
    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(1920);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(1080);
    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(65536);

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_TRANSFORM = 1'b1;
    localparam logic REG_WIDTH    = 1'b0;
    localparam logic REG_HEIGHT   = 1'b1;

    // Saturates a 64-bit signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -ACC_W'(64'sd2147483648);
        if (v > hi) begin
            return DATA_W'(32'h7fff_ffff);
        end else if (v < lo) begin
            return DATA_W'(32'h8000_0000);
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/w2s_ram.sv =====
// ----------------------------------------------------------------------------
// w2s_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module w2s_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/world_to_screen_projector_top.sv =====
// ----------------------------------------------------------------------------
// world_to_screen_projector_top
// Projects a world point through view and projection matrices to screen space.
//
// Channel   Direction  Handshake              Payload
// command   in         start, busy            i_operation, i_coef_index,
//                                             i_coef_value, i_pos_x/y/z
// result    out        o_result_valid strobe  o_screen_x, o_screen_y
// config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// A load writes the coefficient RAMs and leaves busy low. A transform holds
// busy high through the multiply-accumulate passes of the single multiplier
// fed by the two coefficient RAM copies, then two restoring divides, each
// followed by the mapping states MQ, MM and MA. The result strobe lasts one cycle and
// cannot be held off. Reset is synchronous and leaves the coefficients
// undefined; the screen size returns to 1920 by 1080.
// ----------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projector_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_operation,
    input  wire logic [w2s_pkg::ADDR_W-1:0]           i_coef_index,
    input  wire logic signed [w2s_pkg::DATA_W-1:0]    i_coef_value,
    input  wire logic signed [w2s_pkg::DATA_W-1:0]    i_pos_x,
    input  wire logic signed [w2s_pkg::DATA_W-1:0]    i_pos_y,
    input  wire logic signed [w2s_pkg::DATA_W-1:0]    i_pos_z,
    input  wire logic                                 i_cfg_we,
    input  wire logic                                 i_cfg_index,
    input  wire logic [w2s_pkg::DIM_W-1:0]            i_cfg_data,
    output logic                                      o_result_valid,
    output logic signed [w2s_pkg::DATA_W-1:0]         o_screen_x,
    output logic signed [w2s_pkg::DATA_W-1:0]         o_screen_y
);

    import w2s_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_RD   = 11'b000_0000_0010,
        ST_W1   = 11'b000_0000_0100,
        ST_W2   = 11'b000_0000_1000,
        ST_VP   = 11'b000_0001_0000,
        ST_CA   = 11'b000_0010_0000,
        ST_CLIP = 11'b000_0100_0000,
        ST_DIV  = 11'b000_1000_0000,
        ST_MQ   = 11'b001_0000_0000,
        ST_MM   = 11'b010_0000_0000,
        ST_MA   = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    logic [DIM_W-1:0] r_width, r_height;
    logic signed [DATA_W-1:0] r_px, r_py, r_pz, r_cx, r_cy, r_cw, r_m, r_sx;
    logic [1:0] r_i, r_k, r_col;
    logic r_rv, r_pv, r_dsel, r_neg;
    logic signed [ACC_W-1:0] r_acc, r_clip, r_prod;
    logic [DVD_W-1:0] r_dvd;
    logic [DATA_W-1:0] r_rem;
    logic [DCNT_W-1:0] r_cnt;

    logic [DATA_W-1:0] ram_a_q, ram_b_q;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic ram_we;
    logic [1:0] col_j;
    logic signed [DATA_W-1:0] vp, pos_i, mul_a, mul_b, clip_sat, cw_clamp, quo_s;
    logic signed [ACC_W-1:0] prod;
    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic [DATA_W-1:0] dvd_abs_x, dvd_abs_c;
    logic [DIM_W-1:0] dim;
    logic signed [ACC_W-1:0] half, scr_sum;

    assign ram_we = start && !busy && (i_operation == OP_LOAD);
    assign col_j  = (r_col == 2'd2) ? 2'd3 : r_col;
    assign addr_a = {1'b0, r_i, r_k};
    assign addr_b = {1'b1, r_k, col_j};

    w2s_ram #(.WIDTH(DATA_W), .DEPTH(COEF_N)) u_ram_view (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(i_coef_index), .i_wdata(i_coef_value),
        .i_raddr(addr_a), .o_rdata(ram_a_q)
    );

    w2s_ram #(.WIDTH(DATA_W), .DEPTH(COEF_N)) u_ram_proj (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(i_coef_index), .i_wdata(i_coef_value),
        .i_raddr(addr_b), .o_rdata(ram_b_q)
    );

    always_comb begin
        vp       = sat32(r_acc);
        clip_sat = sat32(r_clip);
        cw_clamp = (clip_sat < Q_ONE) ? Q_ONE : clip_sat;
        unique case (r_i)
            2'd0:    pos_i = r_px;
            2'd1:    pos_i = r_py;
            default: pos_i = r_pz;
        endcase
        dim = r_dsel ? r_height : r_width;
        priority if (r_rv) begin
            mul_a = ram_a_q;
            mul_b = ram_b_q;
        end else if (r_state == ST_VP) begin
            mul_a = vp;
            mul_b = pos_i;
        end else begin
            mul_a = DATA_W'({{(DATA_W-DIM_W){1'b0}}, dim});
            mul_b = r_m;
        end
        trial     = {r_rem, r_dvd[DVD_W-1]};
        diff      = trial - {1'b0, r_cw};
        quo_s     = r_neg ? -r_dvd[DATA_W-1:0] : r_dvd[DATA_W-1:0];
        dvd_abs_x = r_cx[DATA_W-1] ? -r_cx : r_cx;
        dvd_abs_c = r_cy[DATA_W-1] ? -r_cy : r_cy;
        half      = r_prod >>> 1;
        scr_sum   = (r_dsel ? -half : half) + ACC_W'(r_m)
                  + ACC_W'({dim, 15'b0});
    end

    assign busy = (r_state != ST_IDLE);
    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_width        <= WIDTH_RST;
            r_height       <= HEIGHT_RST;
            r_rv           <= 1'b0;
            r_pv           <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                endcase
            end
            r_rv           <= (r_state == ST_RD);
            r_pv           <= r_rv;
            o_result_valid <= 1'b0;
            if (r_pv) begin
                r_acc <= r_acc + (r_prod >>> FRAC_W);
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (start && i_operation == OP_TRANSFORM) begin
                        r_px    <= i_pos_x;
                        r_py    <= i_pos_y;
                        r_pz    <= i_pos_z;
                        r_i     <= 2'd0;
                        r_k     <= 2'd0;
                        r_col   <= 2'd0;
                        r_acc   <= '0;
                        r_clip  <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= ST_W1;
                    end
                end
                ST_W1: r_state <= ST_W2;
                ST_W2: r_state <= ST_VP;
                ST_VP: begin
                    r_acc <= '0;
                    if (r_i == 2'd3) begin
                        r_clip  <= r_clip + ACC_W'(vp);
                        r_state <= ST_CLIP;
                    end else begin
                        r_state <= ST_CA;
                    end
                end
                ST_CA: begin
                    r_clip  <= r_clip + (r_prod >>> FRAC_W);
                    r_i     <= r_i + 2'd1;
                    r_state <= ST_RD;
                end
                ST_CLIP: begin
                    r_clip <= '0;
                    r_i    <= 2'd0;
                    unique case (r_col)
                        2'd0:    r_cx <= clip_sat;
                        2'd1:    r_cy <= clip_sat;
                        default: r_cw <= cw_clamp;
                    endcase
                    if (r_col == 2'd2) begin
                        r_dvd   <= {dvd_abs_x, {FRAC_W{1'b0}}};
                        r_neg   <= r_cx[DATA_W-1];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_dsel  <= 1'b0;
                        r_state <= ST_DIV;
                    end else begin
                        r_col   <= r_col + 2'd1;
                        r_state <= ST_RD;
                    end
                end
                ST_DIV: begin
                    if (!diff[DATA_W]) begin
                        r_rem <= diff[DATA_W-1:0];
                        r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
                    end else begin
                        r_rem <= trial[DATA_W-1:0];
                        r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + DCNT_W'(1);
                    if (r_cnt == DCNT_W'(DVD_W - 1)) begin
                        r_state <= ST_MQ;
                    end
                end
                ST_MQ: begin
                    r_m     <= quo_s;
                    r_state <= ST_MM;
                end
                ST_MM: r_state <= ST_MA;
                ST_MA: begin
                    if (!r_dsel) begin
                        r_sx    <= sat32(scr_sum);
                        r_dvd   <= {dvd_abs_c, {FRAC_W{1'b0}}};
                        r_neg   <= r_cy[DATA_W-1];
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_dsel  <= 1'b1;
                        r_state <= ST_DIV;
                    end else begin
                        o_screen_x     <= r_sx;
                        o_screen_y     <= sat32(scr_sum);
                        o_result_valid <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_result_ends_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while still busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a transform in flight");

    a_transform_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_TRANSFORM) |=> busy)
        else $error("transform transfer did not start work");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_LOAD) |=> !busy && !o_result_valid)
        else $error("load transfer started work");

endmodule

`default_nettype wire
